>>> rtl/core/cnd_pkg.sv
// shared constants and types for the contour normals and distances block
`timescale 1ns / 1ps
`default_nettype none
package cnd_pkg;
	// store geometry
	localparam int MAX_POINTS = 64;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// field widths
	localparam int COORD_W = 24;
	localparam int AREA_W  = 56;
	localparam int DIST_W  = 32;
	localparam int NRM_W   = 16;

	// vector unit widths
	localparam int VEC_W      = 26;
	localparam int MAG_W      = VEC_W - 1;
	localparam int SQ_W       = 2 * MAG_W + 1;
	localparam int ROOT_W     = 64;
	localparam int ROOT_STEPS = ROOT_W / 2;
	localparam int LEN_W      = 32;
	localparam int LEN_SHIFT  = 14;
	localparam int DIST_SHIFT = LEN_SHIFT / 2;
	localparam int NUM_SHIFT  = 23;
	localparam int NUM_W      = 50;
	localparam int QSTEPS     = NRM_W - 1;
	localparam int QCNT_W     = $clog2(QSTEPS);

	// near-zero limits on squared length
	localparam logic [SQ_W-1:0] DIR_EPS = SQ_W'(16);
	localparam logic [SQ_W-1:0] NRM_EPS = SQ_W'(1073);
	localparam logic signed [NRM_W-1:0] UNIT_Q15 = 16'sd32767;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [NRM_W-1:0]   nrm_t;

	// request to the vector unit
	typedef struct packed {
		logic signed [VEC_W-1:0] dx;
		logic signed [VEC_W-1:0] dy;
		logic                    nrm;
	} vec_req_t;

	// answer of the vector unit
	typedef struct packed {
		logic             nz;
		logic [LEN_W-1:0] len;
		nrm_t             ux;
		nrm_t             uy;
	} vec_res_t;
endpackage
`default_nettype wire

>>> rtl/core/cnd_if.sv
// handshake channels of the contour block: points, results and configuration
`timescale 1ns / 1ps
`default_nettype none
interface cnd_pt_if;
	logic            valid;
	logic            ready;
	cnd_pkg::coord_t pos_x;
	cnd_pkg::coord_t pos_y;
	logic            last_point;
	modport source (output valid, pos_x, pos_y, last_point, input ready);
	modport sink (input valid, pos_x, pos_y, last_point, output ready);
endinterface

interface cnd_res_if;
	logic                          valid;
	logic                          ready;
	cnd_pkg::coord_t               out_x;
	cnd_pkg::coord_t               out_y;
	logic [cnd_pkg::DIST_W-1:0]    arc_length;
	cnd_pkg::nrm_t                 normal_x;
	cnd_pkg::nrm_t                 normal_y;
	logic                          overflowed;
	logic                          last_result;
	modport source (output valid, out_x, out_y, arc_length, normal_x, normal_y, overflowed,
		last_result, input ready);
	modport sink (input valid, out_x, out_y, arc_length, normal_x, normal_y, overflowed,
		last_result, output ready);
endinterface

interface cnd_cfg_if;
	logic valid;
	logic ready;
	logic closed_contour;
	modport source (output valid, closed_contour, input ready);
	modport sink (input valid, closed_contour, output ready);
endinterface
`default_nettype wire

>>> rtl/core/cnd_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module cnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/core/cnd_vec.sv
// iterative vector unit: squared length, square root and unit components
`timescale 1ns / 1ps
`default_nettype none
module cnd_vec (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire cnd_pkg::vec_req_t req,
	output logic                   done,
	output cnd_pkg::vec_res_t      res
);
	typedef enum logic [3:0] {
		V_IDLE, V_SQX, V_SQY, V_CHK, V_ROOT, V_DSET, V_DSAT, V_DIV, V_DONE
	} vstate_t;

	vstate_t                             state_q;
	logic [cnd_pkg::MAG_W-1:0]           ax_q, ay_q;
	logic                                sx_q, sy_q, nrm_q, ysel_q;
	logic [cnd_pkg::SQ_W-1:0]            s_q;
	logic [cnd_pkg::ROOT_W-1:0]          rem_q, root_q;
	logic [$clog2(cnd_pkg::ROOT_STEPS)-1:0] k_q;
	logic [cnd_pkg::NUM_W-1:0]           num_q, den_q;
	logic [cnd_pkg::QCNT_W-1:0]          b_q;
	logic [cnd_pkg::QSTEPS-1:0]          quot_q;

	logic [cnd_pkg::MAG_W-1:0]   mul_a;
	logic [2*cnd_pkg::MAG_W-1:0] sq_c;
	logic [cnd_pkg::ROOT_W-1:0]  bit_c, tst_c, root_nx;
	logic                        root_ge;
	logic [cnd_pkg::MAG_W-1:0]   mag_c;
	logic                        sgn_c;
	logic [cnd_pkg::NUM_W-1:0]   num_set, den_sh;
	logic                        div_ge, sat_c;
	logic [cnd_pkg::QSTEPS-1:0]  quot_nx;
	logic [cnd_pkg::SQ_W-1:0]    eps_c;

	// shared squarer
	assign mul_a = (state_q == V_SQX) ? ax_q : ay_q;
	assign sq_c  = mul_a * mul_a;

	// one root step, two bits of the radicand
	assign bit_c   = cnd_pkg::ROOT_W'(1) << {k_q, 1'b0};
	assign tst_c   = root_q + bit_c;
	assign root_ge = rem_q >= tst_c;
	assign root_nx = root_ge ? ((root_q >> 1) + bit_c) : (root_q >> 1);

	// one quotient bit per step, rounding term folded into the dividend
	assign mag_c   = ysel_q ? ay_q : ax_q;
	assign sgn_c   = ysel_q ? sy_q : sx_q;
	assign num_set = cnd_pkg::NUM_W'({mag_c, cnd_pkg::NUM_SHIFT'(0)}) +
		cnd_pkg::NUM_W'(res.len);
	assign den_sh  = den_q << b_q;
	assign div_ge  = num_q >= den_sh;
	assign sat_c   = num_q >= (den_q << cnd_pkg::QSTEPS);
	assign quot_nx = quot_q | (cnd_pkg::QSTEPS'(div_ge) << b_q);
	assign eps_c   = nrm_q ? cnd_pkg::NRM_EPS : cnd_pkg::DIR_EPS;

	assign done = (state_q == V_DONE);

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
		end else begin
			case (state_q)
				V_IDLE: begin
					if (start) begin
						ax_q    <= cnd_pkg::MAG_W'(req.dx < 0 ? -req.dx : req.dx);
						ay_q    <= cnd_pkg::MAG_W'(req.dy < 0 ? -req.dy : req.dy);
						sx_q    <= req.dx < 0;
						sy_q    <= req.dy < 0;
						nrm_q   <= req.nrm;
						state_q <= V_SQX;
					end
				end
				V_SQX: begin
					s_q     <= cnd_pkg::SQ_W'(sq_c);
					state_q <= V_SQY;
				end
				V_SQY: begin
					s_q     <= s_q + cnd_pkg::SQ_W'(sq_c);
					state_q <= V_CHK;
				end
				V_CHK: begin
					res.nz  <= s_q <= eps_c;
					rem_q   <= {s_q[cnd_pkg::ROOT_W-cnd_pkg::LEN_SHIFT-1:0],
						cnd_pkg::LEN_SHIFT'(0)};
					root_q  <= '0;
					k_q     <= '1;
					state_q <= V_ROOT;
				end
				V_ROOT: begin
					if (root_ge) begin
						rem_q <= rem_q - tst_c;
					end
					root_q <= root_nx;
					if (k_q == '0) begin
						res.len <= root_nx[cnd_pkg::LEN_W-1:0];
						ysel_q  <= 1'b0;
						state_q <= res.nz ? V_DONE : V_DSET;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				V_DSET: begin
					num_q   <= num_set;
					den_q   <= cnd_pkg::NUM_W'({res.len, 1'b0});
					quot_q  <= '0;
					b_q     <= cnd_pkg::QCNT_W'(cnd_pkg::QSTEPS - 1);
					state_q <= V_DSAT;
				end
				V_DSAT: begin
					if (sat_c) begin
						if (ysel_q) begin
							res.uy  <= sgn_c ? -cnd_pkg::UNIT_Q15 : cnd_pkg::UNIT_Q15;
							state_q <= V_DONE;
						end else begin
							res.ux  <= sgn_c ? -cnd_pkg::UNIT_Q15 : cnd_pkg::UNIT_Q15;
							ysel_q  <= 1'b1;
							state_q <= V_DSET;
						end
					end else begin
						state_q <= V_DIV;
					end
				end
				V_DIV: begin
					if (div_ge) begin
						num_q <= num_q - den_sh;
					end
					quot_q <= quot_nx;
					if (b_q == '0) begin
						if (ysel_q) begin
							res.uy  <= sgn_c ? -$signed({1'b0, quot_nx}) : $signed({1'b0, quot_nx});
							state_q <= V_DONE;
						end else begin
							res.ux  <= sgn_c ? -$signed({1'b0, quot_nx}) : $signed({1'b0, quot_nx});
							ysel_q  <= 1'b1;
							state_q <= V_DSET;
						end
					end else begin
						b_q <= b_q - 1'b1;
					end
				end
				V_DONE: begin
					state_q <= V_IDLE;
				end
				default: begin
					state_q <= V_IDLE;
				end
			endcase
		end
	end

	// a new request only finds the unit free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == V_IDLE)
		else $error("vector request while unit busy");

	// completion lasts one cycle
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> state_q == V_IDLE)
		else $error("vector unit stuck after completion");
endmodule
`default_nettype wire

>>> rtl/core/contour_normals_and_distances.sv
// top level: contour point store, shoelace area, arc length and vertex normals
//
//  channel   dir  handshake      word
//  points    in   valid/ready    pos_x, pos_y, last_point
//  results   out  valid/ready    out_x, out_y, arc_length, normal_x, normal_y,
//                                overflowed, last_result
//  cfg       in   valid/ready    closed_contour (ready always high)
//
// loading: a point is accepted, then S_A1 to S_A3 multiply and accumulate its area
// terms; the first and dropped points skip those steps.
// on the last point: S_C1 to S_C3 close the area, then each stored point takes
// three passes through the shared vector unit when two or more are stored
// (32-step square root and up to two 15-step divisions each).
// a finished word sits in the output register while the next point is worked
// on; a point waits in the output stage only if the previous word is not taken.
// reset clears the point count, flags, sums and the register; the store needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module contour_normals_and_distances (
	input wire logic  clk,
	input wire logic  arst_n,
	cnd_pt_if.sink    points,
	cnd_res_if.source results,
	cnd_cfg_if.sink   cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_A1, S_A2, S_A3, S_C1, S_C2, S_C3, S_RD0W, S_RD, S_RDW,
		S_VIN, S_VOUT, S_VSUM, S_OUT
	} state_t;

	state_t                            state_q;
	logic [cnd_pkg::CNT_W-1:0]         cnt_q;
	logic                              drop_q, closed_q, right_q, lastp_q;
	logic signed [cnd_pkg::AREA_W-1:0] area_q;
	logic [cnd_pkg::DIST_W-1:0]        dist_q;
	cnd_pkg::coord_t                   px_q, py_q, lx_q, ly_q, fx_q, fy_q;
	cnd_pkg::coord_t                   pvx_q, pvy_q, cvx_q, cvy_q, nvx_q, nvy_q;
	logic signed [2*cnd_pkg::COORD_W-1:0] prod_q;
	logic [cnd_pkg::ADDR_W-1:0]        i_q;
	cnd_pkg::nrm_t                     pdx_q, pdy_q, nnx_q, nny_q, nrx_q, nry_q;
	cnd_pkg::vec_req_t                 vreq_q;
	logic                              vstart_q;
	logic                              out_vld_q;

	// ram ports
	logic                              we;
	logic [cnd_pkg::ADDR_W-1:0]        raddr;
	logic [2*cnd_pkg::COORD_W-1:0]     rdata;
	cnd_pkg::coord_t                   rd_x, rd_y;

	// vector unit ports
	logic                              vdone;
	cnd_pkg::vec_res_t                 vres;

	// arithmetic helpers
	cnd_pkg::coord_t                   mul_a, mul_b;
	logic signed [2*cnd_pkg::COORD_W-1:0] prod_c;
	logic signed [cnd_pkg::AREA_W-1:0] area_fin;
	logic                              accept, has_next, is_last;
	cnd_pkg::coord_t                   nxt_x, nxt_y;
	cnd_pkg::nrm_t                     ndx, ndy, pnx, pny, nnx, nny;
	logic [cnd_pkg::DIST_W:0]          dist_sum;

	assign accept        = points.valid && points.ready;
	assign points.ready  = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;
	assign we            = accept && (cnt_q < cnd_pkg::CNT_W'(cnd_pkg::MAX_POINTS));
	assign raddr         = (state_q == S_RD) ? i_q + 1'b1 : '0;
	assign rd_x          = rdata[2*cnd_pkg::COORD_W-1:cnd_pkg::COORD_W];
	assign rd_y          = rdata[cnd_pkg::COORD_W-1:0];
	assign has_next      = (cnd_pkg::CNT_W'(i_q) + 1'b1) < cnt_q;
	assign is_last       = (cnd_pkg::CNT_W'(i_q) + 1'b1) == cnt_q;

	// point store, x in the upper half
	cnd_ram #(
		.WIDTH(2 * cnd_pkg::COORD_W),
		.DEPTH(cnd_pkg::MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(cnd_pkg::ADDR_W'(cnt_q)),
		.wdata({points.pos_x, points.pos_y}),
		.raddr(raddr),
		.rdata(rdata)
	);

	// shared length and unit vector unit
	cnd_vec u_vec (
		.clk   (clk),
		.arst_n(arst_n),
		.start (vstart_q),
		.req   (vreq_q),
		.done  (vdone),
		.res   (vres)
	);

	// cross product operands for the shoelace terms
	always_comb begin
		case (state_q)
			S_A1:    begin mul_a = lx_q; mul_b = py_q; end
			S_A2:    begin mul_a = px_q; mul_b = ly_q; end
			S_C1:    begin mul_a = lx_q; mul_b = fy_q; end
			default: begin mul_a = fx_q; mul_b = ly_q; end
		endcase
	end
	assign prod_c   = mul_a * mul_b;
	assign area_fin = area_q - cnd_pkg::AREA_W'(prod_q);

	// next neighbour, wrapping or clamped at the open end
	always_comb begin
		if (has_next) begin
			nxt_x = rd_x;
			nxt_y = rd_y;
		end else if (closed_q) begin
			nxt_x = fx_q;
			nxt_y = fy_q;
		end else begin
			nxt_x = cvx_q;
			nxt_y = cvy_q;
		end
	end

	// outgoing direction and the normals of the incoming and outgoing edges
	assign ndx = vres.nz ? pdx_q : vres.ux;
	assign ndy = vres.nz ? pdy_q : vres.uy;
	assign pnx = right_q ? pdy_q : -pdy_q;
	assign pny = right_q ? -pdx_q : pdx_q;
	assign nnx = right_q ? ndy : -ndy;
	assign nny = right_q ? -ndx : ndx;

	// saturating arc length
	assign dist_sum = {1'b0, dist_q} +
		(cnd_pkg::DIST_W + 1)'(vres.len >> cnd_pkg::DIST_SHIFT);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= 1'b0;
		end else if (cfg.valid) begin
			closed_q <= cfg.closed_contour;
		end
	end

	// vector unit start pulse, one per pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vstart_q <= 1'b0;
		end else begin
			vstart_q <= (state_q == S_RDW && cnt_q >= cnd_pkg::CNT_W'(2)) ||
				((state_q == S_VIN || state_q == S_VOUT) && vdone);
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			drop_q    <= 1'b0;
			area_q    <= '0;
			dist_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (results.ready && state_q != S_OUT) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						lastp_q <= points.last_point;
						if (we) begin
							px_q <= points.pos_x;
							py_q <= points.pos_y;
							if (cnt_q == '0) begin
								fx_q    <= points.pos_x;
								fy_q    <= points.pos_y;
								lx_q    <= points.pos_x;
								ly_q    <= points.pos_y;
								cnt_q   <= cnd_pkg::CNT_W'(1);
								state_q <= points.last_point ? S_C1 : S_IDLE;
							end else begin
								state_q <= S_A1;
							end
						end else begin
							drop_q  <= 1'b1;
							state_q <= points.last_point ? S_C1 : S_IDLE;
						end
					end
				end
				S_A1: begin
					prod_q  <= prod_c;
					state_q <= S_A2;
				end
				S_A2: begin
					area_q  <= area_q + cnd_pkg::AREA_W'(prod_q);
					prod_q  <= prod_c;
					state_q <= S_A3;
				end
				S_A3: begin
					area_q  <= area_fin;
					lx_q    <= px_q;
					ly_q    <= py_q;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= lastp_q ? S_C1 : S_IDLE;
				end
				S_C1: begin
					prod_q  <= prod_c;
					state_q <= S_C2;
				end
				S_C2: begin
					area_q  <= area_q + cnd_pkg::AREA_W'(prod_q);
					prod_q  <= prod_c;
					state_q <= S_C3;
				end
				S_C3: begin
					area_q  <= area_fin;
					right_q <= closed_q && (area_fin > 0);
					state_q <= S_RD0W;
				end
				S_RD0W: begin
					cvx_q   <= rd_x;
					cvy_q   <= rd_y;
					pvx_q   <= closed_q ? lx_q : rd_x;
					pvy_q   <= closed_q ? ly_q : rd_y;
					i_q     <= '0;
					dist_q  <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					state_q <= S_RDW;
				end
				S_RDW: begin
					nvx_q <= nxt_x;
					nvy_q <= nxt_y;
					if (cnt_q < cnd_pkg::CNT_W'(2)) begin
						nrx_q   <= '0;
						nry_q   <= '0;
						state_q <= S_OUT;
					end else begin
						vreq_q.dx  <= cnd_pkg::VEC_W'(cvx_q) - cnd_pkg::VEC_W'(pvx_q);
						vreq_q.dy  <= cnd_pkg::VEC_W'(cvy_q) - cnd_pkg::VEC_W'(pvy_q);
						vreq_q.nrm <= 1'b0;
						state_q    <= S_VIN;
					end
				end
				S_VIN: begin
					if (vdone) begin
						pdx_q <= vres.nz ? cnd_pkg::UNIT_Q15 : vres.ux;
						pdy_q <= vres.nz ? '0 : vres.uy;
						if (i_q != '0) begin
							dist_q <= dist_sum[cnd_pkg::DIST_W] ? '1 :
								dist_sum[cnd_pkg::DIST_W-1:0];
						end
						vreq_q.dx  <= cnd_pkg::VEC_W'(nvx_q) - cnd_pkg::VEC_W'(cvx_q);
						vreq_q.dy  <= cnd_pkg::VEC_W'(nvy_q) - cnd_pkg::VEC_W'(cvy_q);
						vreq_q.nrm <= 1'b0;
						state_q    <= S_VOUT;
					end
				end
				S_VOUT: begin
					if (vdone) begin
						nnx_q      <= nnx;
						nny_q      <= nny;
						vreq_q.dx  <= cnd_pkg::VEC_W'(pnx) + cnd_pkg::VEC_W'(nnx);
						vreq_q.dy  <= cnd_pkg::VEC_W'(pny) + cnd_pkg::VEC_W'(nny);
						vreq_q.nrm <= 1'b1;
						state_q    <= S_VSUM;
					end
				end
				S_VSUM: begin
					if (vdone) begin
						nrx_q   <= vres.nz ? nnx_q : vres.ux;
						nry_q   <= vres.nz ? nny_q : vres.uy;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_vld_q || results.ready) begin
						out_vld_q           <= 1'b1;
						results.out_x       <= cvx_q;
						results.out_y       <= cvy_q;
						results.arc_length  <= dist_q;
						results.normal_x    <= nrx_q;
						results.normal_y    <= nry_q;
						results.overflowed  <= drop_q;
						results.last_result <= is_last;
						if (is_last) begin
							cnt_q   <= '0;
							drop_q  <= 1'b0;
							area_q  <= '0;
							dist_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							pvx_q   <= cvx_q;
							pvy_q   <= cvy_q;
							cvx_q   <= nvx_q;
							cvy_q   <= nvy_q;
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid = out_vld_q;

	// the store never holds more than its depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cnd_pkg::CNT_W'(cnd_pkg::MAX_POINTS))
		else $error("point count beyond store depth");

	// a new word appears only from the output step
	a_word_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !$past(out_vld_q)) |-> $past(state_q == S_OUT))
		else $error("result word raised outside output step");

	// vector requests only while walking the contour
	a_vec_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vstart_q |-> (state_q == S_VIN || state_q == S_VOUT || state_q == S_VSUM))
		else $error("vector request outside emission");
endmodule
`default_nettype wire
